// ----- rtl/core/sds_pkg.sv -----
// Shared types and constants for the scale degree stepper.
// Used by the step datapath and the top level; no dependencies.
package sds_pkg;

	localparam int POS_W    = 9;
	localparam int TABLE_W  = 64;
	localparam int COUNT_W  = 4;
	localparam int CFG_IDX_W = 2;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEGREE_TABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE_COUNT = 2'd1;

	// one input transaction, mode in bit 0
	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic                    wrap_enable;
		logic                    mode;
	} in_item_t;

	localparam int IN_ITEM_W = $bits(in_item_t);

endpackage

// ----- rtl/core/sds_step.sv -----
// Combinational next-degree logic: ascending table, mirrored table, compares.
// Depends on sds_pkg.
module sds_step #(
	parameter int MAX_DEGREES = 8,
	parameter int DEGREE_BITS = 8
) (
	input  logic [sds_pkg::TABLE_W-1:0]      degree_table,
	input  logic [sds_pkg::COUNT_W-1:0]      degree_count,
	input  sds_pkg::in_item_t                item,
	output logic signed [sds_pkg::POS_W-1:0] next_position
);

	localparam int CNT_W  = $clog2(MAX_DEGREES + 1);
	localparam int CW     = (CNT_W > sds_pkg::COUNT_W) ? CNT_W : sds_pkg::COUNT_W;
	localparam int VAL_W  = ((DEGREE_BITS > sds_pkg::POS_W) ? DEGREE_BITS : sds_pkg::POS_W) + 2;
	localparam int PACK_W = MAX_DEGREES * DEGREE_BITS;
	localparam int PAD_W  = (PACK_W > sds_pkg::TABLE_W) ? PACK_W : sds_pkg::TABLE_W;

	typedef logic signed [VAL_W-1:0] val_t;

	logic [PAD_W-1:0] tbl_pad;
	val_t             asc [MAX_DEGREES];
	val_t             mir [MAX_DEGREES];
	logic [CW-1:0]    cnt_ext;
	logic [CNT_W-1:0] n_act;
	val_t             top;
	val_t             lowest;
	val_t             second;
	val_t             p_ext;
	logic [CNT_W-1:0] cnt_le;
	logic [CNT_W-1:0] cnt_lt;
	val_t             asc_above;
	val_t             asc_below;
	logic             found;
	logic [CNT_W-1:0] k_match;
	val_t             mir_prev;
	val_t             mir_next;
	val_t             r;

	assign tbl_pad = PAD_W'(degree_table);
	assign p_ext   = val_t'(item.position);

	always_comb begin
		for (int i = 0; i < MAX_DEGREES; i++) begin
			asc[i] = val_t'({1'b0, tbl_pad[i*DEGREE_BITS +: DEGREE_BITS]});
		end
	end

	// active count: zero acts as one, saturates at the table size
	always_comb begin
		cnt_ext = CW'(degree_count);
		if (cnt_ext == '0) begin
			n_act = CNT_W'(1);
		end else if (cnt_ext > CW'(MAX_DEGREES)) begin
			n_act = CNT_W'(MAX_DEGREES);
		end else begin
			n_act = cnt_ext[CNT_W-1:0];
		end
	end

	always_comb begin
		top = '0;
		for (int j = 0; j < MAX_DEGREES; j++) begin
			if (CNT_W'(j + 1) == n_act) begin
				top = asc[j];
			end
		end
	end

	// mirror entry i = degree[n-1-i] - top
	always_comb begin
		for (int i = 0; i < MAX_DEGREES; i++) begin
			mir[i] = '0;
			for (int j = 0; j < MAX_DEGREES; j++) begin
				if ((CNT_W+1)'(i + j + 1) == (CNT_W+1)'(n_act)) begin
					mir[i] = asc[j] - top;
				end
			end
		end
		lowest = asc[0] - top;
		second = (n_act > CNT_W'(1)) ? mir[1] : '0;
	end

	always_comb begin
		cnt_le = '0;
		cnt_lt = '0;
		for (int i = 0; i < MAX_DEGREES; i++) begin
			if (CNT_W'(i) < n_act) begin
				if (asc[i] <= p_ext) begin
					cnt_le = cnt_le + CNT_W'(1);
				end
				if (asc[i] < p_ext) begin
					cnt_lt = cnt_lt + CNT_W'(1);
				end
			end
		end
	end

	always_comb begin
		asc_above = '0;
		asc_below = '0;
		for (int j = 0; j < MAX_DEGREES; j++) begin
			if (CNT_W'(j) == cnt_le) begin
				asc_above = asc[j];
			end
			if (CNT_W'(j + 1) == cnt_lt) begin
				asc_below = asc[j];
			end
		end
	end

	// first mirror entry equal to the position
	always_comb begin
		found   = 1'b0;
		k_match = '0;
		for (int i = MAX_DEGREES - 1; i >= 0; i--) begin
			if (CNT_W'(i) < n_act && mir[i] == p_ext) begin
				found   = 1'b1;
				k_match = CNT_W'(i);
			end
		end
	end

	always_comb begin
		mir_prev = '0;
		mir_next = '0;
		for (int j = 0; j < MAX_DEGREES; j++) begin
			if (CNT_W'(j + 1) == k_match) begin
				mir_prev = mir[j];
			end
			if (CNT_W'(j) == k_match + CNT_W'(1)) begin
				mir_next = mir[j];
			end
		end
	end

	always_comb begin
		if (!item.mode) begin
			if (!item.position[sds_pkg::POS_W-1]) begin
				if (cnt_le < n_act) begin
					r = asc_above;
				end else begin
					r = item.wrap_enable ? lowest : p_ext;
				end
			end else if (!found) begin
				r = p_ext;
			end else if (k_match == '0) begin
				r = '0;
			end else begin
				r = mir_prev;
			end
		end else begin
			if (!item.position[sds_pkg::POS_W-1]) begin
				if (cnt_lt != '0) begin
					r = asc_below;
				end else begin
					r = second;
				end
			end else if (found && (k_match + CNT_W'(1) < n_act)) begin
				r = mir_next;
			end else begin
				r = item.wrap_enable ? top : p_ext;
			end
		end
	end

	assign next_position = r[sds_pkg::POS_W-1:0];

endmodule

// ----- rtl/core/scale_degree_stepper.sv -----
// Scale degree stepper top level: stream ports, config registers, two-stage pipe.
// Depends on sds_pkg and sds_step.
//
// Takes one transaction per cycle and returns one result per transaction:
// an input register feeds the next-degree compare logic, whose result lands
// in the output register. Throughput is set by that single pass; tready drops
// only while both registers hold data and the output side stalls. Write the
// degree table and count only while no transaction is in flight.
module scale_degree_stepper #(
	parameter int MAX_DEGREES = 8,
	parameter int DEGREE_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [0] mode, [1] wrap_enable, [10:2] position, [15:11] zero
	input  logic [sds_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [8:0] next_position, [15:9] zero
	output logic [sds_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [sds_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sds_pkg::TABLE_W-1:0]         cfg_data
);

	logic [sds_pkg::TABLE_W-1:0]      table_q;
	logic [sds_pkg::COUNT_W-1:0]      count_q;
	sds_pkg::in_item_t                item_s1;
	logic                             valid_s1;
	logic signed [sds_pkg::POS_W-1:0] result_s2;
	logic                             valid_s2;
	logic signed [sds_pkg::POS_W-1:0] step_res;
	logic                             adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_q <= '0;
			count_q <= sds_pkg::COUNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				sds_pkg::REG_DEGREE_TABLE: table_q <= cfg_data;
				sds_pkg::REG_DEGREE_COUNT: count_q <= cfg_data[sds_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= s_tdata[sds_pkg::IN_ITEM_W-1:0];
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= step_res;
		end
	end

	sds_step #(
		.MAX_DEGREES (MAX_DEGREES),
		.DEGREE_BITS (DEGREE_BITS)
	) u_step (
		.degree_table  (table_q),
		.degree_count  (count_q),
		.item          (item_s1),
		.next_position (step_res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = sds_pkg::OUT_TDATA_W'(unsigned'(result_s2));

endmodule

// ----- rtl/core/sds_checker.sv -----
// Port-level checks for the scale degree stepper, bound to the top level.
// Depends on sds_pkg.
module sds_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [sds_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	// an accepted transaction shows up at the output once the output side is ready
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
		else $error("result missing after accepted transaction");

	// empty output stage never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// draining output frees the input side in the same cycle
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

endmodule

bind scale_degree_stepper sds_checker u_sds_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
